// ===== sv/cle_pkg.sv =====
package cle_pkg;

  localparam int BUF_SIZE_DEF = 64;
  localparam int POS_W        = 7;
  localparam int CHAR_W       = 8;
  localparam int QUEUE_DEPTH  = 2;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 24;

  localparam logic [CHAR_W-1:0] KEY_ESC   = 8'h1B;
  localparam logic [CHAR_W-1:0] KEY_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] KEY_DEL   = 8'h7F;
  localparam logic [CHAR_W-1:0] KEY_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] KEY_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CSI_OPEN  = 8'h5B;
  localparam logic [CHAR_W-1:0] CSI_RIGHT = 8'h43;
  localparam logic [CHAR_W-1:0] CSI_LEFT  = 8'h44;
  localparam logic [CHAR_W-1:0] PRINT_LO  = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI  = 8'h7E;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_RIGHT  = 3'd3,
    CMD_LEFT   = 3'd4,
    CMD_EMIT   = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CHAR_W-1:0]  ch;
  } cmd_t;

endpackage

// ===== sv/cle_front.sv =====
module cle_front
  import cle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,   // key_byte
  output logic                  push,
  output cmd_t                  push_cmd,
  input  logic                  queue_full
);

  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_SEEN = 3'b010,
    ESC_CSI  = 3'b100
  } esc_state_t;

  esc_state_t esc_state, esc_state_next;
  logic [CHAR_W-1:0] c;

  assign s_tready = !queue_full;
  assign push     = s_tvalid && s_tready;
  assign c        = s_tdata;

  always_comb begin
    esc_state_next = ESC_IDLE;
    push_cmd.kind  = CMD_NONE;
    push_cmd.ch    = c;
    unique case (esc_state)
      ESC_SEEN: begin
        if (c == CSI_OPEN) begin
          esc_state_next = ESC_CSI;
        end
      end
      ESC_CSI: begin
        if (c == CSI_RIGHT) begin
          push_cmd.kind = CMD_RIGHT;
        end else if (c == CSI_LEFT) begin
          push_cmd.kind = CMD_LEFT;
        end
      end
      default: begin
        if (c == KEY_ESC) begin
          esc_state_next = ESC_SEEN;
        end else if (c >= PRINT_LO && c <= PRINT_HI) begin
          push_cmd.kind = CMD_INSERT;
        end else if (c == KEY_BS || c == KEY_DEL) begin
          push_cmd.kind = CMD_DELETE;
        end else if (c == KEY_CR || c == KEY_LF) begin
          push_cmd.kind = CMD_EMIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_state <= ESC_IDLE;
    end else if (push) begin
      esc_state <= esc_state_next;
    end
  end

endmodule

// ===== sv/cle_queue.sv =====
module cle_queue
  import cle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/cle_back.sv =====
module cle_back
  import cle_pkg::*;
#(
  parameter int BUF_SIZE = BUF_SIZE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_pop,
  input  cmd_t                   cmd,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [7:0] line_char, [14:8] cursor_pos, [21:15] line_length, [23:22] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tuser,   // [0] line_valid
  output logic                   m_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } back_state_t;

  back_state_t state, state_next;
  logic [POS_W-1:0]  cursor, cursor_next;
  logic [POS_W-1:0]  length, length_next;
  logic [POS_W-1:0]  remain, remain_next;
  logic [CHAR_W-1:0] store [BUF_SIZE];

  logic              out_free;
  logic              do_insert, do_delete, do_shift_out;
  logic              out_load, out_valid_next;
  logic              o_line_valid;
  logic [CHAR_W-1:0] o_line_char;
  logic [POS_W-1:0]  o_cursor, o_length;
  logic              o_last;
  logic [POS_W-1:0]  cursor_dec;

  assign out_free   = !m_tvalid || m_tready;
  assign cursor_dec = cursor - 1'b1;

  always_comb begin
    state_next     = state;
    cursor_next    = cursor;
    length_next    = length;
    remain_next    = remain;
    cmd_pop        = 1'b0;
    do_insert      = 1'b0;
    do_delete      = 1'b0;
    do_shift_out   = 1'b0;
    out_load       = 1'b0;
    out_valid_next = 1'b0;
    o_line_valid   = 1'b0;
    o_line_char    = '0;
    o_last         = 1'b1;
    unique case (state)
      ST_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          o_line_valid   = 1'b1;
          o_line_char    = store[0];
          o_last         = (remain == POS_W'(1));
          do_shift_out   = 1'b1;
          remain_next    = remain - 1'b1;
          if (remain == POS_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        if (out_free) begin
          out_load = 1'b1;
          cmd_pop  = cmd_valid;
          if (cmd_valid) begin
            out_valid_next = 1'b1;
            unique case (cmd.kind)
              CMD_INSERT: begin
                if (length < POS_W'(BUF_SIZE)) begin
                  do_insert   = 1'b1;
                  cursor_next = cursor + 1'b1;
                  length_next = length + 1'b1;
                end
              end
              CMD_DELETE: begin
                if (cursor != '0) begin
                  do_delete   = 1'b1;
                  cursor_next = cursor_dec;
                  length_next = length - 1'b1;
                end
              end
              CMD_RIGHT: begin
                if (cursor < length) begin
                  cursor_next = cursor + 1'b1;
                end
              end
              CMD_LEFT: begin
                if (cursor != '0) begin
                  cursor_next = cursor_dec;
                end
              end
              CMD_EMIT: begin
                cursor_next = '0;
                length_next = '0;
                if (length != '0) begin
                  // The characters follow one per cycle from the head of the row while the output is free.
                  out_valid_next = 1'b0;
                  remain_next    = length;
                  state_next     = ST_EMIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    endcase
    o_cursor = cursor_next;
    o_length = length_next;
  end

  // Each cell loads from its own neighbors: right shift on insert, left
  // shift on delete and while a finished line drains out of cell zero.
  for (genvar j = 0; j < BUF_SIZE; j++) begin : g_cell
    logic [CHAR_W-1:0] left_nb;
    logic [CHAR_W-1:0] right_nb;
    logic [POS_W-1:0]  idx;

    assign idx = POS_W'(j);
    if (j == 0) begin : g_first
      assign left_nb = '0;
    end else begin : g_inner_l
      assign left_nb = store[j-1];
    end
    if (j == BUF_SIZE - 1) begin : g_last
      assign right_nb = '0;
    end else begin : g_inner_r
      assign right_nb = store[j+1];
    end

    always_ff @(posedge clk) begin
      if (do_insert) begin
        if (idx == cursor) begin
          store[j] <= cmd.ch;
        end else if (idx > cursor && idx <= length) begin
          store[j] <= left_nb;
        end
      end else if (do_delete) begin
        if (idx >= cursor_dec && (idx + 1'b1) < length) begin
          store[j] <= right_nb;
        end
      end else if (do_shift_out) begin
        store[j] <= right_nb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cursor   <= '0;
      length   <= '0;
      remain   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      length <= length_next;
      remain <= remain_next;
      if (out_load) begin
        m_tvalid <= out_valid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, o_length, o_cursor, o_line_char};
      m_tuser <= o_line_valid;
      m_tlast <= o_last;
    end
  end

endmodule

// ===== sv/console_line_editor.sv =====
// Console line editor.
// The input stream (s_tvalid, s_tready, s_tdata) carries one received console
// byte per transaction. Printable bytes are inserted at the cursor, BS and DEL
// remove the character before it, ESC [ C and ESC [ D move it right and left.
// The output stream (m_tvalid, m_tready, m_tdata, m_tuser, m_tlast) carries
// results; tuser is set when a transaction carries a character of a completed
// line. There is one status transaction per byte, except that CR or LF on a
// non-empty line gives one transaction per stored character, tlast on the last.
// A front parser classifies each byte and pushes a command into a two-entry
// queue; the editor behind it runs one command per cycle while the output is
// free, on a row of shifting character cells, and owns the output register.
// A result passes through the queue and then the output register.
// Throughput: one byte per cycle for editing bytes while the output is free; a
// line end occupies the editor until the single output register has drained
// every stored character out of the cell row.
// Reset clears the cursor, the length, the escape parser and the queue.
// When the receiver holds m_tready low, the output register holds its
// transaction, the editor stops, and s_tready drops once the queue is full.
module console_line_editor
  import cle_pkg::*;
#(
  parameter int BUF_SIZE = BUF_SIZE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] key_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [7:0] line_char, [14:8] cursor_pos, [21:15] line_length, [23:22] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tuser,   // [0] line_valid
  output logic                   m_tlast
);

  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic pop_valid;
  logic pop;
  cmd_t pop_cmd;

  cle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  cle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_cmd   (pop_cmd)
  );

  cle_back #(
    .BUF_SIZE (BUF_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_pop   (pop),
    .cmd       (pop_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
